### rtl/prc_pkg.sv
// Shared constants and the CORDIC arctangent table for the point rotation core.
`timescale 1ns / 1ps

package prc_pkg;

  localparam int DEF_COORD_BITS    = 16;
  localparam int DEF_CORDIC_STAGES = 16;

  // Angle input format: signed, 1/64 degree per LSB.
  localparam int ANGLE_BITS   = 16;
  localparam int FULL_TURN    = 360 * 64;
  localparam int HALF_TURN    = 180 * 64;
  localparam int QUARTER_TURN = 90 * 64;
  // The CORDIC angle accumulator counts 2^-22 degree, the input angle times 2^16.
  localparam int ANGLE_SHIFT  = 16;

  // CORDIC datapath: Q28 vector, 32-bit angle residual.
  localparam int XY_BITS = 32;
  localparam int Z_BITS  = 32;
  localparam int FRAC    = 28;
  localparam logic signed [XY_BITS-1:0] GAIN_Q28 = 32'sd163008219;

  // round(atan(2^-idx) in degrees * 2^22).
  function automatic logic signed [Z_BITS-1:0] atan_q22(input int idx);
    logic signed [Z_BITS-1:0] val;
    case (idx)
      0:       val = 32'sd188743680;
      1:       val = 32'sd111421900;
      2:       val = 32'sd58872272;
      3:       val = 32'sd29884485;
      4:       val = 32'sd15000234;
      5:       val = 32'sd7507429;
      6:       val = 32'sd3754631;
      7:       val = 32'sd1877430;
      8:       val = 32'sd938729;
      9:       val = 32'sd469366;
      10:      val = 32'sd234683;
      11:      val = 32'sd117342;
      12:      val = 32'sd58671;
      13:      val = 32'sd29335;
      14:      val = 32'sd14668;
      15:      val = 32'sd7334;
      16:      val = 32'sd3667;
      17:      val = 32'sd1833;
      18:      val = 32'sd917;
      19:      val = 32'sd458;
      20:      val = 32'sd229;
      21:      val = 32'sd115;
      22:      val = 32'sd57;
      23:      val = 32'sd29;
      24:      val = 32'sd14;
      25:      val = 32'sd7;
      26:      val = 32'sd4;
      27:      val = 32'sd2;
      28:      val = 32'sd1;
      default: val = 32'sd0;
    endcase
    return val;
  endfunction

endpackage

### rtl/prc_prep.sv
// Input stage: angle folding into [-90, 90] degrees and offsets from the center.
`timescale 1ns / 1ps

module prc_prep import prc_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [ANGLE_BITS-1:0] angle_deg,
  output logic                         vld,
  output logic signed [XY_BITS-1:0]    x,
  output logic signed [XY_BITS-1:0]    y,
  output logic signed [Z_BITS-1:0]     z,
  output logic signed [COORD_BITS:0]   dx,
  output logic signed [COORD_BITS:0]   dy,
  output logic signed [COORD_BITS-1:0] cx,
  output logic signed [COORD_BITS-1:0] cy,
  output logic                         flip
);

  localparam int DW = COORD_BITS + 1;
  localparam int AW = ANGLE_BITS + 1;

  localparam logic signed [AW-1:0] A_FULL    = AW'(FULL_TURN);
  localparam logic signed [AW-1:0] A_HALF    = AW'(HALF_TURN);
  localparam logic signed [AW-1:0] A_QUARTER = AW'(QUARTER_TURN);

  logic signed [AW-1:0] a_ext;
  logic signed [AW-1:0] a_wrap;
  logic signed [AW-1:0] a_fold;
  logic                 flip_next;

  // A 16-bit angle lies within one and a half turns, so a single correction
  // brings it into [-180, 180) degrees.
  always_comb begin
    a_ext = AW'(angle_deg);
    if (a_ext >= A_HALF) begin
      a_wrap = a_ext - A_FULL;
    end else if (a_ext < -A_HALF) begin
      a_wrap = a_ext + A_FULL;
    end else begin
      a_wrap = a_ext;
    end
    flip_next = 1'b0;
    if (a_wrap > A_QUARTER) begin
      a_fold    = a_wrap - A_HALF;
      flip_next = 1'b1;
    end else if (a_wrap < -A_QUARTER) begin
      a_fold    = a_wrap + A_HALF;
      flip_next = 1'b1;
    end else begin
      a_fold = a_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= GAIN_Q28;
      y    <= '0;
      z    <= Z_BITS'(a_fold) <<< ANGLE_SHIFT;
      dx   <= DW'(point_x) - DW'(center_x);
      dy   <= DW'(point_y) - DW'(center_y);
      cx   <= center_x;
      cy   <= center_y;
      flip <= flip_next;
    end
  end

endmodule

### rtl/prc_cell.sv
// One CORDIC micro-rotation cell that also carries the point geometry along.
`timescale 1ns / 1ps

module prc_cell import prc_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int STAGE      = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic signed [XY_BITS-1:0]    x_in,
  input  logic signed [XY_BITS-1:0]    y_in,
  input  logic signed [Z_BITS-1:0]     z_in,
  input  logic signed [COORD_BITS:0]   dx_in,
  input  logic signed [COORD_BITS:0]   dy_in,
  input  logic signed [COORD_BITS-1:0] cx_in,
  input  logic signed [COORD_BITS-1:0] cy_in,
  input  logic                         flip_in,
  output logic                         vld,
  output logic signed [XY_BITS-1:0]    x,
  output logic signed [XY_BITS-1:0]    y,
  output logic signed [Z_BITS-1:0]     z,
  output logic signed [COORD_BITS:0]   dx,
  output logic signed [COORD_BITS:0]   dy,
  output logic signed [COORD_BITS-1:0] cx,
  output logic signed [COORD_BITS-1:0] cy,
  output logic                         flip
);

  localparam logic signed [Z_BITS-1:0] ATAN = atan_q22(STAGE);

  logic signed [XY_BITS-1:0] x_sh;
  logic signed [XY_BITS-1:0] y_sh;
  logic signed [XY_BITS-1:0] x_next;
  logic signed [XY_BITS-1:0] y_next;
  logic signed [Z_BITS-1:0]  z_next;

  // Rotate toward a zero residual; a non-negative residual turns counterclockwise.
  always_comb begin
    x_sh = x_in >>> STAGE;
    y_sh = y_in >>> STAGE;
    if (!z_in[Z_BITS-1]) begin
      x_next = x_in - y_sh;
      y_next = y_in + x_sh;
      z_next = z_in - ATAN;
    end else begin
      x_next = x_in + y_sh;
      y_next = y_in - x_sh;
      z_next = z_in + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      dx   <= dx_in;
      dy   <= dy_in;
      cx   <= cx_in;
      cy   <= cy_in;
      flip <= flip_in;
    end
  end

endmodule

### rtl/prc_post.sv
// Back end: products, sums, center offset, rounding and saturation.
`timescale 1ns / 1ps

module prc_post import prc_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         vld_in,
  input  logic signed [XY_BITS-1:0]    x_in,
  input  logic signed [XY_BITS-1:0]    y_in,
  input  logic signed [COORD_BITS:0]   dx_in,
  input  logic signed [COORD_BITS:0]   dy_in,
  input  logic signed [COORD_BITS-1:0] cx_in,
  input  logic signed [COORD_BITS-1:0] cy_in,
  input  logic                         flip_in,
  output logic                         res_vld,
  output logic signed [COORD_BITS-1:0] res_x,
  output logic signed [COORD_BITS-1:0] res_y,
  output logic                         res_clip
);

  localparam int PW = COORD_BITS + 1 + XY_BITS;
  localparam int SW = PW + 1;
  localparam int TW = SW + 1;
  localparam int RW = TW - FRAC;

  localparam logic signed [TW-1:0] HALF_T = TW'(1) <<< (FRAC - 1);
  localparam logic signed [RW-1:0] SAT_HI =
    RW'((longint'(1) <<< (COORD_BITS - 1)) - longint'(1));
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  // Product stage.
  logic                         m_vld;
  logic signed [PW-1:0]         p_dxx, p_dyy, p_dyx, p_dxy;
  logic signed [COORD_BITS-1:0] m_cx, m_cy;
  logic                         m_flip;

  // Sum stage.
  logic                         s_vld;
  logic signed [SW-1:0]         s_x, s_y;
  logic signed [COORD_BITS-1:0] s_cx, s_cy;
  logic                         s_flip;

  // Center offset stage, Q28.
  logic                         t_vld;
  logic signed [TW-1:0]         t_x, t_y;

  // Rounded integers.
  logic                         r_vld;
  logic signed [RW-1:0]         r_x, r_y;

  logic signed [TW-1:0] cx_q, cy_q;
  logic signed [TW-1:0] tx_next, ty_next;
  logic signed [TW-1:0] tx_adj, ty_adj;
  logic                 clip_x, clip_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
      s_vld <= 1'b0;
      t_vld <= 1'b0;
      r_vld <= 1'b0;
    end else if (en) begin
      m_vld <= vld_in;
      s_vld <= m_vld;
      t_vld <= s_vld;
      r_vld <= t_vld;
    end
  end

  // A flipped angle negates both sine and cosine, so the sums are negated
  // instead of the factors.
  always_comb begin
    cx_q = TW'(s_cx) <<< FRAC;
    cy_q = TW'(s_cy) <<< FRAC;
    if (s_flip) begin
      tx_next = cx_q - TW'(s_x);
      ty_next = cy_q - TW'(s_y);
    end else begin
      tx_next = cx_q + TW'(s_x);
      ty_next = cy_q + TW'(s_y);
    end
  end

  // Half away from zero: adding half and flooring, less one LSB for negatives.
  always_comb begin
    tx_adj = t_x + HALF_T - $signed(TW'(t_x[TW-1]));
    ty_adj = t_y + HALF_T - $signed(TW'(t_y[TW-1]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_dxx  <= PW'(dx_in) * PW'(x_in);
      p_dyy  <= PW'(dy_in) * PW'(y_in);
      p_dyx  <= PW'(dy_in) * PW'(x_in);
      p_dxy  <= PW'(dx_in) * PW'(y_in);
      m_cx   <= cx_in;
      m_cy   <= cy_in;
      m_flip <= flip_in;

      s_x    <= SW'(p_dxx) + SW'(p_dyy);
      s_y    <= SW'(p_dyx) - SW'(p_dxy);
      s_cx   <= m_cx;
      s_cy   <= m_cy;
      s_flip <= m_flip;

      t_x    <= tx_next;
      t_y    <= ty_next;

      r_x    <= RW'(tx_adj >>> FRAC);
      r_y    <= RW'(ty_adj >>> FRAC);
    end
  end

  always_comb begin
    clip_x = 1'b1;
    clip_y = 1'b1;
    if (r_x > SAT_HI) begin
      res_x = SAT_HI[COORD_BITS-1:0];
    end else if (r_x < SAT_LO) begin
      res_x = SAT_LO[COORD_BITS-1:0];
    end else begin
      res_x  = r_x[COORD_BITS-1:0];
      clip_x = 1'b0;
    end
    if (r_y > SAT_HI) begin
      res_y = SAT_HI[COORD_BITS-1:0];
    end else if (r_y < SAT_LO) begin
      res_y = SAT_LO[COORD_BITS-1:0];
    end else begin
      res_y  = r_y[COORD_BITS-1:0];
      clip_y = 1'b0;
    end
    res_clip = clip_x | clip_y;
    res_vld  = r_vld;
  end

endmodule

### rtl/prc_obuf.sv
// Output register with a skid entry; its free slot gates the whole pipeline.
`timescale 1ns / 1ps

module prc_obuf #(
  parameter int WIDTH = 33
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             p_vld,
  input  logic [WIDTH-1:0] p_data,
  output logic             en,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic             skid_vld;
  logic [WIDTH-1:0] skid_data;
  logic             push;
  logic             pop;

  assign en   = !skid_vld;
  assign push = p_vld && en;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (pop) begin
        skid_vld <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_vld <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_data <= p_data;
      end else begin
        out_data <= p_data;
      end
    end
  end

endmodule

### rtl/point_rotation_about_center_core.sv
// Registered path to out_valid: prep stage, CORDIC cells, back-end stages, output buffer.
// Throughput: one request per cycle from the CORDIC chain, while the skid entry is empty.
// in_ready drops only while the skid entry of the output buffer holds a result.
// Reset (rst, synchronous, active high) clears every valid bit and the output buffer.
// Data registers are not reset; no state survives between requests.
`timescale 1ns / 1ps

module point_rotation_about_center_core import prc_pkg::*; #(
  parameter int COORD_BITS    = DEF_COORD_BITS,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [ANGLE_BITS-1:0] angle_deg,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] rotated_x,
  output logic signed [COORD_BITS-1:0] rotated_y,
  output logic                         clipped
);

  localparam int OBW = 2 * COORD_BITS + 1;

  // Pipeline advance. Every stage moves together when the output buffer has
  // room; the buffer's skid entry absorbs the one result that arrives while
  // the consumer is stalled, so in_ready is a plain register output.
  logic en;

  // Cell chain taps. Index 0 is the prep stage, index CORDIC_STAGES the last cell.
  logic                         c_vld  [0:CORDIC_STAGES];
  logic signed [XY_BITS-1:0]    c_x    [0:CORDIC_STAGES];
  logic signed [XY_BITS-1:0]    c_y    [0:CORDIC_STAGES];
  logic signed [Z_BITS-1:0]     c_z    [0:CORDIC_STAGES];
  logic signed [COORD_BITS:0]   c_dx   [0:CORDIC_STAGES];
  logic signed [COORD_BITS:0]   c_dy   [0:CORDIC_STAGES];
  logic signed [COORD_BITS-1:0] c_cx   [0:CORDIC_STAGES];
  logic signed [COORD_BITS-1:0] c_cy   [0:CORDIC_STAGES];
  logic                         c_flip [0:CORDIC_STAGES];

  logic                         res_vld;
  logic signed [COORD_BITS-1:0] res_x;
  logic signed [COORD_BITS-1:0] res_y;
  logic                         res_clip;
  logic [OBW-1:0]               ob_data;

  assign in_ready = en;

  // The prep stage folds the angle into [-90, 90] degrees, remembering whether
  // 180 degrees was added or removed, and forms the offsets from the center.
  // The CORDIC vector starts at the limit gain on the x axis, so no final gain
  // multiply is needed.
  prc_prep #(
    .COORD_BITS (COORD_BITS)
  ) u_prep (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (in_valid),
    .point_x   (point_x),
    .point_y   (point_y),
    .center_x  (center_x),
    .center_y  (center_y),
    .angle_deg (angle_deg),
    .vld       (c_vld[0]),
    .x         (c_x[0]),
    .y         (c_y[0]),
    .z         (c_z[0]),
    .dx        (c_dx[0]),
    .dy        (c_dy[0]),
    .cx        (c_cx[0]),
    .cy        (c_cy[0]),
    .flip      (c_flip[0])
  );

  // One micro-rotation per cell. Each cell hands its vector, residual angle
  // and the request's geometry to the next cell on every advancing cycle, so
  // CORDIC_STAGES requests are in flight along the row at once.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    prc_cell #(
      .COORD_BITS (COORD_BITS),
      .STAGE      (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .vld_in  (c_vld[i]),
      .x_in    (c_x[i]),
      .y_in    (c_y[i]),
      .z_in    (c_z[i]),
      .dx_in   (c_dx[i]),
      .dy_in   (c_dy[i]),
      .cx_in   (c_cx[i]),
      .cy_in   (c_cy[i]),
      .flip_in (c_flip[i]),
      .vld     (c_vld[i+1]),
      .x       (c_x[i+1]),
      .y       (c_y[i+1]),
      .z       (c_z[i+1]),
      .dx      (c_dx[i+1]),
      .dy      (c_dy[i+1]),
      .cx      (c_cx[i+1]),
      .cy      (c_cy[i+1]),
      .flip    (c_flip[i+1])
    );
  end

  // The last cell's x and y are cosine and sine in Q28. The back end takes
  // four registered stages: products, sums, center offset with the flip
  // applied, and rounding. Saturation is decided on the rounded value as it
  // enters the output buffer.
  prc_post #(
    .COORD_BITS (COORD_BITS)
  ) u_post (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (c_vld[CORDIC_STAGES]),
    .x_in     (c_x[CORDIC_STAGES]),
    .y_in     (c_y[CORDIC_STAGES]),
    .dx_in    (c_dx[CORDIC_STAGES]),
    .dy_in    (c_dy[CORDIC_STAGES]),
    .cx_in    (c_cx[CORDIC_STAGES]),
    .cy_in    (c_cy[CORDIC_STAGES]),
    .flip_in  (c_flip[CORDIC_STAGES]),
    .res_vld  (res_vld),
    .res_x    (res_x),
    .res_y    (res_y),
    .res_clip (res_clip)
  );

  assign ob_data = {res_clip, res_y, res_x};

  prc_obuf #(
    .WIDTH (OBW)
  ) u_obuf (
    .clk       (clk),
    .rst       (rst),
    .p_vld     (res_vld),
    .p_data    (ob_data),
    .en        (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  ({clipped, rotated_y, rotated_x})
  );

endmodule

### test/point_rotation_checker.sv
// Checker for the point rotation core: predicts each rotated point and compares results.
`timescale 1ns / 1ps

module point_rotation_checker import prc_pkg::*; #(
  parameter int COORD_BITS    = DEF_COORD_BITS,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [ANGLE_BITS-1:0] angle_deg,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [COORD_BITS-1:0] rotated_x,
  input  logic signed [COORD_BITS-1:0] rotated_y,
  input  logic                         clipped,
  output int                           fail_count,
  output int                           outstanding
);

  localparam longint START_X    = 64'sd163008219;  // round(K * 2^28)

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         clip;
  } rotated_point_t;

  // Arctangent of 2^-i in degrees, scaled by 2^22.
  longint atan_steps [0:31] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429, 3754631,
    1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0
  };

  rotated_point_t expected_points [$];

  // Round a Q28 value half away from zero to an integer.
  function automatic longint round_q28(input longint v);
    longint half;
    half = longint'(1) <<< (FRAC - 1);
    if (v >= 0) return (v + half) >>> FRAC;
    return -((-v + half) >>> FRAC);
  endfunction

  function automatic longint clamp_coord(input longint v, inout bit clip);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic rotated_point_t rotate_about_center(
    input logic signed [COORD_BITS-1:0] px, py, cx, cy,
    input logic signed [ANGLE_BITS-1:0] ang
  );
    longint a, z, x, y, xs, ys, c, s, dx, dy, rx, ry;
    bit flip;
    bit clip;
    rotated_point_t r;
    flip = 1'b0;
    clip = 1'b0;
    a = longint'(ang);
    a = a % FULL_TURN;
    if (a >= HALF_TURN) a -= FULL_TURN;
    if (a < -HALF_TURN) a += FULL_TURN;
    if (a > QUARTER_TURN) begin
      a -= HALF_TURN;
      flip = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a += HALF_TURN;
      flip = 1'b1;
    end
    z = a <<< ANGLE_SHIFT;
    x = START_X;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= atan_steps[i];
      end else begin
        x += ys;
        y -= xs;
        z += atan_steps[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    dx = longint'(px) - longint'(cx);
    dy = longint'(py) - longint'(cy);
    rx = round_q28(dx * c + dy * s + (longint'(cx) <<< FRAC));
    ry = round_q28(dy * c - dx * s + (longint'(cy) <<< FRAC));
    rx = clamp_coord(rx, clip);
    ry = clamp_coord(ry, clip);
    r.x = rx[COORD_BITS-1:0];
    r.y = ry[COORD_BITS-1:0];
    r.clip = clip;
    return r;
  endfunction

  function automatic void report(input string what, input longint want, input longint got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    rotated_point_t want;
    if (rst) begin
      expected_points.delete();
    end else begin
      if (in_valid && in_ready)
        expected_points.push_back(
          rotate_about_center(point_x, point_y, center_x, center_y, angle_deg));
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, actual x=%0d y=%0d clipped=%0d",
                   $time, rotated_x, rotated_y, clipped);
        end else begin
          want = expected_points.pop_front();
          if (rotated_x !== want.x) report("rotated_x", want.x, rotated_x);
          if (rotated_y !== want.y) report("rotated_y", want.y, rotated_y);
          if (clipped !== want.clip) report("clipped", want.clip, clipped);
        end
      end
    end
    outstanding <= expected_points.size();
  end

endmodule

### test/tb_point_rotation_about_center_core.sv
// Testbench top for the point rotation core: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_point_rotation_about_center_core;
  import prc_pkg::*;

  localparam int COORD_BITS    = DEF_COORD_BITS;
  localparam int CORDIC_STAGES = DEF_CORDIC_STAGES;
  localparam int RANDOM_POINTS = 630;
  localparam int DRAIN_CYCLES  = 40;      // comfortably past the pipeline latency
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 120;     // long enough to fill the pipeline and skid
  localparam int DEG           = 64;      // angle units per degree

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [ANGLE_BITS-1:0] angle_deg;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [COORD_BITS-1:0] rotated_x;
  logic signed [COORD_BITS-1:0] rotated_y;
  logic                         clipped;

  int fail_count;
  int outstanding;

  // Set once the random part starts; the receiver uses it to place its long hold-off
  // where the sender is busy.
  bit random_phase;

  // Sender burst state: requests left in the current burst.
  int burst_left;

  point_rotation_about_center_core #(
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .point_x  (point_x),
    .point_y  (point_y),
    .center_x (center_x),
    .center_y (center_y),
    .angle_deg(angle_deg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .rotated_x(rotated_x),
    .rotated_y(rotated_y),
    .clipped  (clipped)
  );

  point_rotation_checker #(
    .COORD_BITS   (COORD_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .center_x   (center_x),
    .center_y   (center_y),
    .angle_deg  (angle_deg),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rotated_x  (rotated_x),
    .rotated_y  (rotated_y),
    .clipped    (clipped),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request. Called at a falling edge; returns at the falling edge after the
  // request was taken. Between bursts the sender drops valid for a random gap, and a
  // quarter of the gaps are empty so that long back-to-back stretches occur too.
  task automatic send_point(input logic signed [COORD_BITS-1:0] px, py, cx, cy,
                            input logic signed [ANGLE_BITS-1:0] ang);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    point_x   <= px;
    point_y   <= py;
    center_x  <= cx;
    center_y  <= cy;
    angle_deg <= ang;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Hold the sender off until every predicted result has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
      1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // Random request. Most points are moderate so that the rotation lands in range, a
  // part uses the full coordinate range or its corners to drive saturation, and some
  // angles sit right on or next to multiples of a quarter turn.
  task automatic send_random_point();
    int kind;
    int px, py, cx, cy, ang;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      px = $urandom_range(0, 4000); px -= 2000;
      py = $urandom_range(0, 4000); py -= 2000;
      cx = $urandom_range(0, 4000); cx -= 2000;
      cy = $urandom_range(0, 4000); cy -= 2000;
    end else if (kind <= 7) begin
      px = $urandom(); py = $urandom(); cx = $urandom(); cy = $urandom();
    end else if (kind == 8) begin
      px = int'(pick_extreme()); py = int'(pick_extreme());
      cx = int'(pick_extreme()); cy = int'(pick_extreme());
    end else begin
      cx = $urandom(); cy = $urandom();
      px = $urandom_range(0, 64); px = px - 32 + cx;
      py = $urandom_range(0, 64); py = py - 32 + cy;
    end
    if ($urandom_range(0, 4) == 0) begin
      ang = $urandom_range(0, 8); ang = (ang - 4) * QUARTER_TURN;
      ang += $urandom_range(0, 2); ang -= 1;
    end else begin
      ang = $urandom_range(0, 2 * FULL_TURN); ang -= FULL_TURN;
    end
    send_point(px[COORD_BITS-1:0], py[COORD_BITS-1:0], cx[COORD_BITS-1:0],
               cy[COORD_BITS-1:0], ang[ANGLE_BITS-1:0]);
  endtask

  // Receiver. Stretches of steady acceptance, random stalls, alternate-cycle stalls
  // and short full stops follow one another. Once the random part is running it holds
  // off for a long stretch so the pipeline fills and in_ready has to drop.
  initial begin
    int mode;
    int len;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (random_phase && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 9);
        len  = $urandom_range(5, 60);
        for (int k = 0; k < len; k++) begin
          case (mode)
            0, 1, 2, 3: out_ready <= 1'b1;
            4, 5, 6, 7: out_ready <= ($urandom_range(0, 99) >= 30);
            8:          out_ready <= k[0];
            default:    out_ready <= (k >= 15);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[point_rotation_about_center_core] ERROR");
    $finish;
  end

  initial begin
    random_phase = 1'b0;
    burst_left   = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    point_x   = '0;
    point_y   = '0;
    center_x  = '0;
    center_y  = '0;
    angle_deg = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests. Zero angle and an all-zero request.
    send_point(0, 0, 0, 0, 0);
    send_point(1234, -567, 0, 0, 0);
    // Quarter turns both ways, and just past a quarter turn, where the angle is folded
    // by half a turn and sine and cosine change sign.
    send_point(100, 0, 0, 0, ANGLE_BITS'(90 * DEG));
    send_point(100, 0, 0, 0, ANGLE_BITS'(-90 * DEG));
    send_point(300, 200, 10, -20, ANGLE_BITS'(QUARTER_TURN + 1));
    send_point(300, 200, 10, -20, ANGLE_BITS'(-QUARTER_TURN - 1));
    // Half turn exactly, which wraps to minus half a turn, and its negative.
    send_point(500, -250, 40, 40, ANGLE_BITS'(HALF_TURN));
    send_point(500, -250, 40, 40, ANGLE_BITS'(-HALF_TURN));
    // Full turns and angles beyond a quarter turn: reduction modulo 360 degrees.
    send_point(777, 333, -100, 50, ANGLE_BITS'(FULL_TURN));
    send_point(777, 333, -100, 50, ANGLE_BITS'(-FULL_TURN));
    send_point(-1000, 2000, 300, 300, ANGLE_BITS'(270 * DEG));
    send_point(-1000, 2000, 300, 300, ANGLE_BITS'(-270 * DEG));
    send_point(1000, 1000, 0, 0, ANGLE_BITS'(135 * DEG));
    send_point(1000, 1000, 0, 0, ANGLE_BITS'(-135 * DEG));
    // Smallest steps away from zero and a plain diagonal.
    send_point(20000, -20000, 0, 0, 1);
    send_point(20000, -20000, 0, 0, -1);
    send_point(1000, 1000, 0, 0, ANGLE_BITS'(45 * DEG));
    // Saturation: far point swung half a turn past the opposite corner.
    send_point(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, ANGLE_BITS'(HALF_TURN));
    send_point(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, ANGLE_BITS'(90 * DEG));
    send_point(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, ANGLE_BITS'(45 * DEG));
    // Largest offsets rotated by zero stay exact and in range.
    send_point(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 0);
    send_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh5a00);
    send_point(-1, -1, -1, -1, -1);

    random_phase = 1'b1;
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      // Halfway through, let everything drain before going on.
      if (n == RANDOM_POINTS / 2) begin
        wait_for_drain();
        burst_left = 0;
      end
      send_random_point();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[point_rotation_about_center_core] OK");
    end else begin
      $display("[point_rotation_about_center_core] ERROR");
    end
    $finish;
  end

endmodule
